[rtl/cau_pkg.sv]
// shared types, codes and saturation helpers of the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } cau_status_t;

  // one classified request between the front and the back
  typedef struct packed {
    cau_op_t            op;
    logic               dz;
    logic signed [15:0] ar;
    logic signed [15:0] ai;
    logic signed [15:0] br;
    logic signed [15:0] bi;
  } cau_item_t;

  typedef struct packed {
    logic signed [15:0] val;
    logic               sat;
  } cau_sat_t;

  // clamp a wide signed value to 16 bits
  function automatic cau_sat_t sat_wide(input logic signed [33:0] x);
    cau_sat_t r;
    if (x > 34'sd32767) begin
      r.val = 16'sh7fff;
      r.sat = 1'b1;
    end else if (x < -34'sd32768) begin
      r.val = 16'sh8000;
      r.sat = 1'b1;
    end else begin
      r.val = x[15:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // signed quotient from sign, overflow flag and 16-bit magnitude
  function automatic cau_sat_t sat_quot(input logic neg, input logic ovf,
                                        input logic [15:0] q);
    cau_sat_t r;
    if (ovf) begin
      r.val = neg ? 16'sh8000 : 16'sh7fff;
      r.sat = 1'b1;
    end else if (neg) begin
      if (q > 16'd32768) begin
        r.val = 16'sh8000;
        r.sat = 1'b1;
      end else begin
        r.val = -q;
        r.sat = 1'b0;
      end
    end else begin
      if (q > 16'd32767) begin
        r.val = 16'sh7fff;
        r.sat = 1'b1;
      end else begin
        r.val = q;
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[rtl/cau_front.sv]
// front: accepts requests, decodes the opcode and flags a zero divisor
// depends on cau_pkg
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // a_real, a_imag, b_real, b_imag
  input  logic [1:0]  in_tuser,   // opcode
  output logic        item_valid,
  input  logic        item_ready,
  output cau_item_t   item
);

  logic      valid_r, valid_nxt;
  cau_item_t item_r, item_nxt;

  assign in_tready  = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt    = item_r;
    valid_nxt   = valid_r && !item_ready;
    if (in_tvalid && in_tready) begin
      valid_nxt   = 1'b1;
      item_nxt.op = cau_op_t'(in_tuser);
      item_nxt.ar = in_tdata[15:0];
      item_nxt.ai = in_tdata[31:16];
      item_nxt.br = in_tdata[47:32];
      item_nxt.bi = in_tdata[63:48];
      item_nxt.dz = (cau_op_t'(in_tuser) == OP_DIV) &&
                    (in_tdata[47:32] == 16'd0) && (in_tdata[63:48] == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

[rtl/cau_queue.sv]
// two-entry queue between front and back
// depends on cau_pkg
`timescale 1ns / 1ps

module cau_queue import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cau_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output cau_item_t out_item
);

  cau_item_t  mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = mem_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

[rtl/cau_back.sv]
// back: products, combine, 17-stage divider pipeline, saturation, output register
// depends on cau_pkg
`timescale 1ns / 1ps

module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cau_item_t   in_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // res_real, res_imag
  output logic [1:0]  out_tuser    // status
);

  localparam int W    = 48 + FRAC_BITS;  // holds den << 16 and |num| << FRAC_BITS
  localparam int NDIV = 17;              // overflow check plus 16 quotient bits

  typedef struct packed {
    logic               is_div;
    logic               dz;
    logic signed [15:0] er;
    logic signed [15:0] ei;
    cau_status_t        est;
    logic               neg_r;
    logic               neg_i;
    logic               ovf_r;
    logic               ovf_i;
    logic [W-1:0]       rem_r;
    logic [W-1:0]       rem_i;
    logic [31:0]        den;
    logic [15:0]        q_r;
    logic [15:0]        q_i;
  } div_st_t;

  logic en;
  assign en       = !out_tvalid || out_tready;
  assign in_ready = en;

  // stage 1: products
  logic               v1_r;
  cau_op_t            op1_r;
  logic               dz1_r;
  logic signed [15:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [31:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      op1_r  <= in_item.op;
      dz1_r  <= in_item.dz;
      ar1_r  <= in_item.ar;
      ai1_r  <= in_item.ai;
      br1_r  <= in_item.br;
      bi1_r  <= in_item.bi;
      p_rr_r <= in_item.ar * in_item.br;
      p_ii_r <= in_item.ai * in_item.bi;
      p_ri_r <= in_item.ar * in_item.bi;
      p_ir_r <= in_item.ai * in_item.br;
      p_bb_r <= in_item.br * in_item.br;
      p_cc_r <= in_item.bi * in_item.bi;
    end
  end

  // stage 2: combine products, early result for add, sub and mul
  div_st_t            st_r   [NDIV+1];
  div_st_t            st_nxt [NDIV+1];
  logic               vld_r  [NDIV+1];
  logic signed [33:0] wr, wi;
  logic signed [32:0] nr, ni;
  logic [31:0]        mr, mi;
  cau_sat_t           sr, si;

  always_comb begin
    wr = '0;
    wi = '0;
    case (op1_r)
      OP_ADD: begin
        wr = 34'(ar1_r) + 34'(br1_r);
        wi = 34'(ai1_r) + 34'(bi1_r);
      end
      OP_SUB: begin
        wr = 34'(ar1_r) - 34'(br1_r);
        wi = 34'(ai1_r) - 34'(bi1_r);
      end
      OP_MUL: begin
        wr = (34'(p_rr_r) - 34'(p_ii_r)) >>> FRAC_BITS;
        wi = (34'(p_ri_r) + 34'(p_ir_r)) >>> FRAC_BITS;
      end
      default: begin
        wr = '0;
        wi = '0;
      end
    endcase
    sr = sat_wide(wr);
    si = sat_wide(wi);
    nr = 33'(p_rr_r) + 33'(p_ii_r);
    ni = 33'(p_ir_r) - 33'(p_ri_r);
    mr = nr[32] ? 32'(-nr) : nr[31:0];
    mi = ni[32] ? 32'(-ni) : ni[31:0];
    st_nxt[0].is_div = (op1_r == OP_DIV);
    st_nxt[0].dz     = dz1_r;
    st_nxt[0].er     = sr.val;
    st_nxt[0].ei     = si.val;
    st_nxt[0].est    = (sr.sat || si.sat) ? ST_SAT : ST_OK;
    st_nxt[0].neg_r  = nr[32];
    st_nxt[0].neg_i  = ni[32];
    st_nxt[0].ovf_r  = 1'b0;
    st_nxt[0].ovf_i  = 1'b0;
    st_nxt[0].rem_r  = W'(mr) << FRAC_BITS;
    st_nxt[0].rem_i  = W'(mi) << FRAC_BITS;
    st_nxt[0].den    = 32'(p_bb_r) + 32'(p_cc_r);
    st_nxt[0].q_r    = '0;
    st_nxt[0].q_i    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= v1_r;
    end
    if (en) begin
      st_r[0] <= st_nxt[0];
    end
  end

  // restoring divider, one quotient bit per stage; first stage detects overflow
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int B  = NDIV - 1 - j;
    localparam int QB = (B > 15) ? 0 : B;  // quotient bit, unused in the overflow stage
    logic [W-1:0] dsh;
    logic         ge_r, ge_i;

    always_comb begin
      st_nxt[j+1] = st_r[j];
      dsh  = W'(st_r[j].den) << B;
      ge_r = (st_r[j].rem_r >= dsh);
      ge_i = (st_r[j].rem_i >= dsh);
      if (j == 0) begin
        st_nxt[j+1].ovf_r = ge_r;
        st_nxt[j+1].ovf_i = ge_i;
      end else begin
        if (ge_r) begin
          st_nxt[j+1].rem_r   = st_r[j].rem_r - dsh;
          st_nxt[j+1].q_r[QB] = 1'b1;
        end
        if (ge_i) begin
          st_nxt[j+1].rem_i   = st_r[j].rem_i - dsh;
          st_nxt[j+1].q_i[QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
      if (en) begin
        st_r[j+1] <= st_nxt[j+1];
      end
    end
  end

  // final selection and output register
  div_st_t            fin;
  cau_sat_t           qr, qi;
  logic signed [15:0] res_r_nxt, res_i_nxt;
  cau_status_t        st_out_nxt;
  logic               ov_r;
  logic signed [15:0] res_r_r, res_i_r;
  cau_status_t        status_r;

  always_comb begin
    fin = st_r[NDIV];
    qr  = sat_quot(fin.neg_r, fin.ovf_r, fin.q_r);
    qi  = sat_quot(fin.neg_i, fin.ovf_i, fin.q_i);
    if (fin.dz) begin
      res_r_nxt  = '0;
      res_i_nxt  = '0;
      st_out_nxt = ST_DIVZ;
    end else if (fin.is_div) begin
      res_r_nxt  = qr.val;
      res_i_nxt  = qi.val;
      st_out_nxt = (qr.sat || qi.sat) ? ST_SAT : ST_OK;
    end else begin
      res_r_nxt  = fin.er;
      res_i_nxt  = fin.ei;
      st_out_nxt = fin.est;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vld_r[NDIV];
    end
    if (en) begin
      res_r_r  <= res_r_nxt;
      res_i_r  <= res_i_nxt;
      status_r <= st_out_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {res_i_r, res_r_r};
  assign out_tuser  = status_r;

endmodule

[rtl/complex_arith_unit_top.sv]
// top level of the complex arithmetic unit: front, queue and back
// depends on cau_pkg, cau_front, cau_queue, cau_back
`timescale 1ns / 1ps

// complex add, subtract, multiply and divide on signed Q8.8 operands, one
// request per cycle sustained while the output is not stalled. a request
// passes the front register, a two-entry queue and the back pipeline: one
// multiply stage, one combine stage, seventeen divider stages (an overflow
// check, then one quotient bit per stage) and the output register. add,
// subtract and multiply ride the same pipeline so results leave in request
// order. every component saturates to 16 bits (status 1); a divide by zero
// gives zero with status 2. the output register stalls the back pipeline,
// while the queue lets the front keep taking requests until it fills.

module complex_arith_unit_top import cau_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // a_real, a_imag, b_real, b_imag
  input  logic [1:0]  in_tuser,    // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // res_real, res_imag
  output logic [1:0]  out_tuser    // status
);

  // front to queue
  logic      f_valid, f_ready;
  cau_item_t f_item;
  // queue to back
  logic      q_valid, q_ready;
  cau_item_t q_item;

  cau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  cau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // back pipeline advances only when the output register can move
  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/cau_checker.sv]
// port-level checks of the complex arithmetic unit, bound to the top level
// depends on complex_arith_unit_top
`timescale 1ns / 1ps

module cau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam logic [1:0] STAT_DIVZ = 2'd2;
  localparam logic [1:0] STAT_BAD  = 2'd3;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != STAT_BAD)
    else $error("undefined status code");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_DIVZ |-> out_tdata == 32'd0)
    else $error("divide by zero with nonzero result");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
